[rtl/sitd_pkg.sv]
// ============================================================================
// sitd_pkg: shared types and constants for the signed integer to decimal unit
// Holds character codes, the BCD step constants, the front state encoding and
// the queue status bundle.
// ============================================================================
package sitd_pkg;

  localparam int unsigned DIGIT_W       = 4;
  localparam int unsigned BITS_PER_STEP = 4;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  localparam logic [DIGIT_W-1:0] DIGIT_ADJ_MIN = 4'd5;
  localparam logic [DIGIT_W-1:0] DIGIT_ADJ     = 4'd3;

  // Decimal digits of the largest magnitude, 2**(w-1); 1233/4096 ~ log10(2).
  function automatic int unsigned digits_for(int unsigned w);
    return (((w - 1) * 1233) >> 12) + 1;
  endfunction

  // Conversion steps of BITS_PER_STEP magnitude bits each.
  function automatic int unsigned steps_for(int unsigned w);
    return (w + BITS_PER_STEP - 1) / BITS_PER_STEP;
  endfunction

  typedef enum logic [2:0] {
    FRONT_IDLE = 3'b001,
    FRONT_CONV = 3'b010,
    FRONT_PUSH = 3'b100
  } sitd_front_state_e;

  typedef struct packed {
    logic full;
    logic empty;
  } sitd_q_status_t;

endpackage

[rtl/sitd_front.sv]
// ============================================================================
// sitd_front: request intake and binary to BCD conversion
// Takes the sign, forms the magnitude and runs double dabble four bits a
// cycle, then finds the leading digit and pushes the request to the queue.
// ============================================================================
module sitd_front #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned NDIG        = 10,
  parameter int unsigned IW          = 4,
  parameter int unsigned ENTRY_W     = 45
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  input  sitd_pkg::sitd_q_status_t   q_status_i,
  output logic                       push_o,
  output logic [ENTRY_W-1:0]         entry_o
);

  localparam int unsigned NSTEP = sitd_pkg::steps_for(VALUE_WIDTH);
  localparam int unsigned MW    = NSTEP * sitd_pkg::BITS_PER_STEP;
  localparam int unsigned BCD_W = NDIG * sitd_pkg::DIGIT_W;
  localparam int unsigned SW    = (NSTEP > 1) ? $clog2(NSTEP) : 1;
  localparam int unsigned BPS   = sitd_pkg::BITS_PER_STEP;
  localparam int unsigned DW    = sitd_pkg::DIGIT_W;

  sitd_pkg::sitd_front_state_e state_q, state_d;
  logic [SW-1:0]    cnt_q, cnt_d;
  logic             neg_q, neg_d;
  logic [MW-1:0]    mag_q, mag_d;
  logic [BCD_W-1:0] bcd_q, bcd_d;

  logic [VALUE_WIDTH-1:0] abs_val;
  logic [BCD_W-1:0] dd_bcd [0:BPS];
  logic [MW-1:0]    dd_mag [0:BPS];
  logic [BCD_W-1:0] adj_v  [0:BPS-1];
  logic [IW-1:0]    top_idx;

  assign abs_val = value_i[VALUE_WIDTH-1] ? (~value_i + VALUE_WIDTH'(1)) : value_i;

  // One conversion step: BITS_PER_STEP rounds of add-3 then shift.
  always_comb begin
    dd_bcd[0] = bcd_q;
    dd_mag[0] = mag_q;
    for (int b = 0; b < BPS; b++) begin
      adj_v[b] = dd_bcd[b];
      for (int d = 0; d < NDIG; d++) begin
        if (adj_v[b][d*DW +: DW] >= sitd_pkg::DIGIT_ADJ_MIN) begin
          adj_v[b][d*DW +: DW] = adj_v[b][d*DW +: DW] + sitd_pkg::DIGIT_ADJ;
        end
      end
      {dd_bcd[b+1], dd_mag[b+1]} = {adj_v[b], dd_mag[b]} << 1;
    end
  end

  // Leading nonzero digit; zero keeps index 0 so a single '0' goes out.
  always_comb begin
    top_idx = '0;
    for (int d = 0; d < NDIG; d++) begin
      if (bcd_q[d*DW +: DW] != '0) begin
        top_idx = IW'(d);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    bcd_d   = bcd_q;
    push_o  = 1'b0;
    case (state_q)
      sitd_pkg::FRONT_IDLE: begin
        if (start) begin
          neg_d   = value_i[VALUE_WIDTH-1];
          mag_d   = MW'(abs_val);
          bcd_d   = '0;
          cnt_d   = SW'(NSTEP - 1);
          state_d = sitd_pkg::FRONT_CONV;
        end
      end
      sitd_pkg::FRONT_CONV: begin
        mag_d = dd_mag[BPS];
        bcd_d = dd_bcd[BPS];
        cnt_d = cnt_q - SW'(1);
        if (cnt_q == '0) begin
          state_d = sitd_pkg::FRONT_PUSH;
        end
      end
      sitd_pkg::FRONT_PUSH: begin
        if (!q_status_i.full) begin
          push_o  = 1'b1;
          state_d = sitd_pkg::FRONT_IDLE;
        end
      end
      default: begin
        state_d = sitd_pkg::FRONT_IDLE;
      end
    endcase
  end

  assign entry_o = {neg_q, top_idx, bcd_q};
  assign busy    = (state_q != sitd_pkg::FRONT_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sitd_pkg::FRONT_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    neg_q <= neg_d;
    mag_q <= mag_d;
    bcd_q <= bcd_d;
  end

endmodule

[rtl/sitd_queue.sv]
// ============================================================================
// sitd_queue: two-entry request queue
// Decouples conversion from character output so each side stalls on its own.
// ============================================================================
module sitd_queue #(
  parameter int unsigned ENTRY_W = 45
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  logic [ENTRY_W-1:0]       entry_i,
  input  logic                     pop_i,
  output logic [ENTRY_W-1:0]       head_o,
  output sitd_pkg::sitd_q_status_t status_o
);

  logic [ENTRY_W-1:0] slot_q [0:1];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign status_o.full  = (count_q == 2'd2);
  assign status_o.empty = (count_q == 2'd0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign head_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

[rtl/sitd_back.sv]
// ============================================================================
// sitd_back: character emitter
// Walks a non-empty queue head: sign first if negative, then digits from the
// top one down, one registered character per cycle; pops on the last digit.
// ============================================================================
module sitd_back #(
  parameter int unsigned NDIG    = 10,
  parameter int unsigned IW      = 4,
  parameter int unsigned ENTRY_W = 45
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [ENTRY_W-1:0]       head_i,
  input  sitd_pkg::sitd_q_status_t q_status_i,
  output logic                     pop_o,
  output logic                     char_valid_o,
  output logic [7:0]               char_code_o,
  output logic                     last_o
);

  localparam int unsigned DW    = sitd_pkg::DIGIT_W;
  localparam int unsigned BCD_W = NDIG * DW;

  logic             head_neg;
  logic [IW-1:0]    head_top;
  logic [BCD_W-1:0] head_bcd;

  logic          started_q, started_d;
  logic [IW-1:0] idx_q, idx_d;
  logic          strobe_q, strobe_d;
  logic [7:0]    char_q, char_d;
  logic          last_q, last_d;
  logic [IW-1:0] cur_idx;
  logic [DW-1:0] cur_digit;

  assign {head_neg, head_top, head_bcd} = head_i;
  assign cur_idx   = started_q ? idx_q : head_top;
  assign cur_digit = head_bcd[cur_idx*DW +: DW];

  always_comb begin
    started_d = started_q;
    idx_d     = idx_q;
    strobe_d  = 1'b0;
    char_d    = char_q;
    last_d    = last_q;
    pop_o     = 1'b0;
    if (!q_status_i.empty) begin
      strobe_d = 1'b1;
      if (head_neg && !started_q) begin
        // Sign goes out first; hold the leading digit index.
        char_d    = sitd_pkg::CHAR_MINUS;
        last_d    = 1'b0;
        started_d = 1'b1;
        idx_d     = head_top;
      end else begin
        char_d = sitd_pkg::CHAR_ZERO + {4'd0, cur_digit};
        last_d = (cur_idx == '0);
        if (cur_idx == '0) begin
          pop_o     = 1'b1;
          started_d = 1'b0;
        end else begin
          started_d = 1'b1;
          idx_d     = cur_idx - IW'(1);
        end
      end
    end
  end

  assign char_valid_o = strobe_q;
  assign char_code_o  = char_q;
  assign last_o       = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      strobe_q  <= 1'b0;
    end else begin
      started_q <= started_d;
      strobe_q  <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    char_q <= char_d;
    last_q <= last_d;
  end

endmodule

[rtl/signed_int_to_decimal_ascii_unit.sv]
// Path to the first character: conversion steps, push state, queue, emitter register.
// Overlap: the front takes a new value only when idle, and converts it while the
//   emitter still sends earlier text; the double-dabble front (4 bits a cycle)
//   and the one-character-a-cycle emitter set the pace.
// Reset: rst_ni clears the front state, queue pointers and output strobe at once.
// Characters leave on char_valid_o for one cycle each; the receiver cannot stall.
// ============================================================================
// signed_int_to_decimal_ascii_unit: signed integer to decimal ASCII text
// Turns one signed integer per request into '-' if negative and decimal digits, most
// significant first, with last marking the final character.
// ============================================================================
module signed_int_to_decimal_ascii_unit #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  output logic                          char_valid_o,
  output logic [7:0]                    char_code_o,
  output logic                          last_o
);

  // Digit count of the widest magnitude, its index width and the queue entry:
  // sign flag, leading digit index and the packed BCD digits.
  localparam int unsigned NDIG    = sitd_pkg::digits_for(VALUE_WIDTH);
  localparam int unsigned IW      = $clog2(NDIG);
  localparam int unsigned ENTRY_W = 1 + IW + NDIG * sitd_pkg::DIGIT_W;

  sitd_pkg::sitd_q_status_t q_status;
  logic                     push;
  logic                     pop;
  logic [ENTRY_W-1:0]       entry;
  logic [ENTRY_W-1:0]       head;

  // Front: take the request, form sign and magnitude, run the BCD conversion
  // and push the finished digits; busy while a conversion is in flight.
  sitd_front #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NDIG        (NDIG),
    .IW          (IW),
    .ENTRY_W     (ENTRY_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .value_i    (value_i),
    .q_status_i (q_status),
    .push_o     (push),
    .entry_o    (entry)
  );

  // Queue: hold up to two converted requests while the emitter drains text.
  sitd_queue #(
    .ENTRY_W (ENTRY_W)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (entry),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  // Back: emit one registered character a cycle from the queue head while the queue is not empty.
  sitd_back #(
    .NDIG    (NDIG),
    .IW      (IW),
    .ENTRY_W (ENTRY_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .q_status_i   (q_status),
    .pop_o        (pop),
    .char_valid_o (char_valid_o),
    .char_code_o  (char_code_o),
    .last_o       (last_o)
  );

endmodule
